[sv/phrt_pkg.sv]
package phrt_pkg;

  // Structural sizes
  localparam int WINDOW_LEN  = 10;
  localparam int BEAT_SLOTS  = 10;
  localparam int SAMPLE_BITS = 12;

  // Fixed constants
  localparam int SEED_VALUE    = 2000;
  localparam int MS_PER_MINUTE = 60000;
  localparam int RATE_MAX      = 255;
  localparam int INTV_MAX      = 65534;

  // Fixed field widths
  localparam int TIME_W     = 32;
  localparam int THR_W      = 12;
  localparam int INTV_W     = 16;
  localparam int RATE_W     = 8;
  localparam int SMOOTH_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int STORE_MAX  = (SEED_VALUE > SAMPLE_MAX) ? SEED_VALUE : SAMPLE_MAX;
  localparam int STORE_W    = $clog2(STORE_MAX + 1);
  localparam int TOT_W      = $clog2(WINDOW_LEN * STORE_MAX + 1);
  localparam int WPOS_W     = $clog2(WINDOW_LEN);
  localparam int BPOS_W     = $clog2(BEAT_SLOTS);
  localparam int CNT_W      = $clog2(BEAT_SLOTS);
  localparam int SUM_W      = $clog2((BEAT_SLOTS - 1) * INTV_MAX + 1);
  localparam int NUM_W      = $clog2(MS_PER_MINUTE * (BEAT_SLOTS - 1) + 1);
  localparam int DIV_W0     = (TOT_W > NUM_W) ? TOT_W : NUM_W;
  localparam int DIV_W      = (DIV_W0 > SUM_W) ? DIV_W0 : SUM_W;
  localparam int DCNT_W     = $clog2(DIV_W);
  localparam int CMP_W0     = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int CMP_W      = CMP_W0 + 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_THR = 3'd0,
    CFG_RELEASE  = 3'd1,
    CFG_MIN_INTV = 3'd2,
    CFG_MAX_INTV = 3'd3,
    CFG_TIMEOUT  = 3'd4
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_RUN,
    ST_WALK_START,
    ST_WALK_RUN,
    ST_RATE_START,
    ST_RATE_RUN,
    ST_POST
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_res_t;

  typedef struct packed {
    logic              write;
    logic [TIME_W-1:0] stamp;
  } beat_rec_t;

  typedef struct packed {
    logic             done;
    logic             full;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } walk_res_t;

endpackage

[sv/phrt_window.sv]
module phrt_window (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic [phrt_pkg::SAMPLE_BITS-1:0]    sample,
  output logic [phrt_pkg::TOT_W-1:0]          total
);
  import phrt_pkg::*;

  logic [STORE_W-1:0] store_r [WINDOW_LEN];
  logic [TOT_W-1:0]   total_r;
  logic [TOT_W-1:0]   total_nxt;
  logic [WPOS_W-1:0]  pos_r;
  logic [WPOS_W-1:0]  pos_nxt;

  // Swap the oldest sample out of the running sum
  always_comb begin
    total_nxt = total_r - TOT_W'(store_r[pos_r]) + TOT_W'(sample);
    pos_nxt   = (pos_r == WPOS_W'(WINDOW_LEN - 1)) ? '0 : pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        store_r[i] <= STORE_W'(SEED_VALUE);
      end
      total_r <= TOT_W'(SEED_VALUE * WINDOW_LEN);
      pos_r   <= '0;
    end else if (load) begin
      store_r[pos_r] <= STORE_W'(sample);
      total_r        <= total_nxt;
      pos_r          <= pos_nxt;
    end
  end

  assign total = total_r;

endmodule

[sv/phrt_beat_ring.sv]
module phrt_beat_ring (
  input  logic                  clk,
  input  logic                  rst_n,
  input  phrt_pkg::beat_rec_t   rec,
  input  logic                  walk_start,
  input  logic [phrt_pkg::INTV_W-1:0] min_intv,
  input  logic [phrt_pkg::INTV_W-1:0] max_intv,
  output phrt_pkg::walk_res_t   res
);
  import phrt_pkg::*;

  logic [TIME_W-1:0] times_r [BEAT_SLOTS];
  logic [BPOS_W-1:0] wpos_r;
  logic [BPOS_W-1:0] wpos_nxt;
  logic              full_r;
  logic              busy_r;
  logic              done_r;
  logic [BPOS_W-1:0] ptr_r;
  logic [BPOS_W-1:0] ptr_nxt;
  logic [BPOS_W-1:0] step_r;
  logic [TIME_W-1:0] prev_r;
  logic [TIME_W-1:0] rd;
  logic [TIME_W-1:0] diff;
  logic              qual;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  count_r;

  // Advance the write slot and the walk pointer around the ring
  always_comb begin
    wpos_nxt = (wpos_r == BPOS_W'(BEAT_SLOTS - 1)) ? '0 : wpos_r + 1'b1;
    ptr_nxt  = (ptr_r == BPOS_W'(BEAT_SLOTS - 1)) ? '0 : ptr_r + 1'b1;
  end

  // One stored time per cycle, interval against the previous one
  always_comb begin
    rd   = times_r[ptr_r];
    diff = rd - prev_r;
    qual = (step_r != '0) && (diff > TIME_W'(min_intv)) && (diff < TIME_W'(max_intv));
  end

  // Record beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BEAT_SLOTS; i++) begin
        times_r[i] <= '0;
      end
      wpos_r <= '0;
      full_r <= 1'b0;
    end else if (rec.write) begin
      times_r[wpos_r] <= rec.stamp;
      wpos_r          <= wpos_nxt;
      if (wpos_nxt == '0) begin
        full_r <= 1'b1;
      end
    end
  end

  // Walk the ring oldest first, accumulating qualifying intervals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ptr_r  <= '0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (walk_start) begin
        busy_r  <= 1'b1;
        ptr_r   <= wpos_r;
        step_r  <= '0;
        sum_r   <= '0;
        count_r <= '0;
      end else if (busy_r) begin
        prev_r <= rd;
        ptr_r  <= ptr_nxt;
        step_r <= step_r + 1'b1;
        if (qual) begin
          sum_r   <= sum_r + SUM_W'(diff[INTV_W-1:0]);
          count_r <= count_r + 1'b1;
        end
        if (step_r == BPOS_W'(BEAT_SLOTS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done  = done_r;
  assign res.full  = full_r;
  assign res.sum   = sum_r;
  assign res.count = count_r;

endmodule

[sv/phrt_serial_div.sv]
module phrt_serial_div (
  input  logic                clk,
  input  logic                rst_n,
  input  phrt_pkg::div_req_t  req,
  output phrt_pkg::div_res_t  res
);
  import phrt_pkg::*;

  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DIV_W-1:0]  den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;
  logic              fits;

  // Shift one dividend bit into the remainder and try the subtract
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, den_r};
    fits    = !trial[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        den_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule

[sv/ppg_heart_rate_tracker_core.sv]
// Each accepted sample runs the window average through the divider; when it starts
// a beat with a full ring, a ring walk and, if any interval qualifies, a rate division follow.
// Throughput: one item at a time; the next sample is taken the cycle after the
// result is posted. The bit-serial divider (one quotient bit per cycle) and
// the one-slot-per-cycle ring walk set how long an item takes.
// Reset (rst_n low, synchronous) seeds the window and restores the control, configuration and tracking registers.
module ppg_heart_rate_tracker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [phrt_pkg::SAMPLE_BITS-1:0]    in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [phrt_pkg::RATE_W-1:0]         out_rate_bpm,
  output logic [phrt_pkg::SAMPLE_BITS-1:0]    out_sample_echo,
  output logic [phrt_pkg::SMOOTH_W-1:0]       out_smoothed,
  output logic                                out_beat,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [phrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phrt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import phrt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  logic [THR_W-1:0]       thr_r;
  logic [THR_W-1:0]       margin_r;
  logic [INTV_W-1:0]      min_r;
  logic [INTV_W-1:0]      max_r;
  logic [INTV_W-1:0]      timeout_r;

  logic                   latched_r;
  logic [TIME_W-1:0]      tick_r;
  logic [TIME_W-1:0]      now_r;
  logic [TIME_W-1:0]      last_beat_r;
  logic [RATE_W-1:0]      held_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   beat_r;
  logic [SMOOTH_W-1:0]    smooth_r;

  logic [RATE_W-1:0]      out_rate_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic [SMOOTH_W-1:0]    out_smooth_r;
  logic                   out_beat_r;
  logic                   out_valid_r;

  logic                   accept;
  logic                   is_beat;
  logic                   rearm;
  logic signed [CMP_W-1:0] release_lvl;
  logic                   silent;
  logic                   post_fire;
  logic                   div_start;
  logic                   walk_start;
  logic                   slot_free;
  logic [NUM_W-1:0]       numer;
  logic [TIME_W-1:0]      idle_span;

  logic [TOT_W-1:0]       total;
  div_req_t               div_req;
  div_res_t               div_res;
  beat_rec_t              rec;
  walk_res_t              walk;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Peak latch with hysteresis
  always_comb begin
    release_lvl = $signed(CMP_W'(thr_r)) - $signed(CMP_W'(margin_r));
    is_beat     = (CMP_W'(in_sample) > CMP_W'(thr_r)) && !latched_r;
    rearm       = $signed(CMP_W'(in_sample)) < release_lvl;
  end

  assign rec.write = accept && is_beat;
  assign rec.stamp = tick_r;

  phrt_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept),
    .sample (in_sample),
    .total  (total)
  );

  phrt_beat_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec        (rec),
    .walk_start (walk_start),
    .min_intv   (min_r),
    .max_intv   (max_r),
    .res        (walk)
  );

  // Pick divider operands: window average or beats per minute
  always_comb begin
    numer         = NUM_W'(MS_PER_MINUTE) * NUM_W'(walk.count);
    div_req.start = div_start;
    if (state_r == ST_AVG_START) begin
      div_req.dividend = DIV_W'(total);
      div_req.divisor  = DIV_W'(WINDOW_LEN);
    end else begin
      div_req.dividend = DIV_W'(numer);
      div_req.divisor  = DIV_W'(walk.sum);
    end
  end

  phrt_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_AVG_START;
      ST_AVG_START:  state_nxt = ST_AVG_RUN;
      ST_AVG_RUN: begin
        if (div_res.done) begin
          state_nxt = (beat_r && walk.full) ? ST_WALK_START : ST_POST;
        end
      end
      ST_WALK_START: state_nxt = ST_WALK_RUN;
      ST_WALK_RUN: begin
        if (walk.done) begin
          state_nxt = (walk.count != '0) ? ST_RATE_START : ST_POST;
        end
      end
      ST_RATE_START: state_nxt = ST_RATE_RUN;
      ST_RATE_RUN:   if (div_res.done) state_nxt = ST_POST;
      ST_POST:       if (slot_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    div_start  = 1'b0;
    walk_start = 1'b0;
    post_fire  = 1'b0;
    case (state_r)
      ST_IDLE:       in_stall   = 1'b0;
      ST_AVG_START:  div_start  = 1'b1;
      ST_WALK_START: walk_start = 1'b1;
      ST_RATE_START: div_start  = 1'b1;
      ST_POST:       post_fire  = slot_free;
      default:       in_stall   = 1'b1;
    endcase
  end

  assign idle_span = now_r - last_beat_r;
  assign silent    = idle_span > TIME_W'(timeout_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_W'(1400);
      margin_r  <= THR_W'(100);
      min_r     <= INTV_W'(300);
      max_r     <= INTV_W'(2000);
      timeout_r <= INTV_W'(2000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RISE_THR: thr_r     <= cfg_data[THR_W-1:0];
        CFG_RELEASE:  margin_r  <= cfg_data[THR_W-1:0];
        CFG_MIN_INTV: min_r     <= cfg_data[INTV_W-1:0];
        CFG_MAX_INTV: max_r     <= cfg_data[INTV_W-1:0];
        CFG_TIMEOUT:  timeout_r <= cfg_data[INTV_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-item tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r   <= 1'b0;
      tick_r      <= '0;
      last_beat_r <= '0;
      held_r      <= '0;
    end else begin
      if (accept) begin
        tick_r <= tick_r + 1'b1;
        if (is_beat) begin
          latched_r   <= 1'b1;
          last_beat_r <= tick_r;
        end else if (rearm) begin
          latched_r <= 1'b0;
        end
      end
      // Saturate the new rate
      if (state_r == ST_RATE_RUN && div_res.done) begin
        held_r <= (div_res.quotient > DIV_W'(RATE_MAX)) ? RATE_W'(RATE_MAX)
                                                        : div_res.quotient[RATE_W-1:0];
      end
      // Drop the rate after a long silence
      if (post_fire && silent) begin
        held_r <= '0;
      end
    end
  end

  // Item payload held while the sequencer runs
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r    <= tick_r;
      sample_r <= in_sample;
      beat_r   <= is_beat;
    end
    if (state_r == ST_AVG_RUN && div_res.done) begin
      smooth_r <= div_res.quotient[SMOOTH_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (post_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_fire) begin
      out_rate_r   <= silent ? '0 : held_r;
      out_sample_r <= sample_r;
      out_smooth_r <= smooth_r;
      out_beat_r   <= beat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rate_bpm    = out_rate_r;
  assign out_sample_echo = out_sample_r;
  assign out_smoothed    = out_smooth_r;
  assign out_beat        = out_beat_r;

endmodule
